FILE: hdl/fsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg - frame signal pack/unpack shared definitions
// Item types, operation and format codes, queue entry layout, byte reversal.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_EXTRACT = 2'd1,
    FUNC_LOAD    = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  // bit numbering formats
  localparam logic [2:0] FMT_INTEL_STD = 3'd0;
  localparam logic [2:0] FMT_INTEL_SEQ = 3'd1;
  localparam logic [2:0] FMT_MOTO_LSB  = 3'd2;
  localparam logic [2:0] FMT_MOTO_MSB  = 3'd3;
  localparam logic [2:0] FMT_MOTO_SEQ  = 3'd4;

  // start bit flips for the sequential and lsb numberings
  localparam logic [5:0] SEQ_FLIP = 6'h07;
  localparam logic [5:0] LSB_FLIP = 6'h38;

  // longest signal
  localparam logic [5:0] MAX_LEN = 6'd32;

  // word index width, covers the largest frame (16 words)
  localparam int WORD_W = 4;

  // input item
  typedef struct packed {
    func_t       func;
    logic [2:0]  format;
    logic [5:0]  start_bit;
    logic [5:0]  length_bits;
    logic [0:0]  word_index;
    logic [31:0] write_value;
  } req_t;

  // result item
  typedef struct packed {
    logic [31:0] read_value;
    logic        status;
  } rsp_t;

  // classified item, front to back
  typedef struct packed {
    func_t             func;
    logic              moto;
    logic              reject;
    logic [WORD_W-1:0] word;
    logic [4:0]        bit_ofs;
    logic [31:0]       mask;
    logic [31:0]       value;
  } cmd_t;

  // queue head toward the back part
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic [31:0] byte_rev(input logic [31:0] x);
    byte_rev = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

FILE: hdl/fsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_front - item classifier
// Turns a request into a linear bit position, word, offset and mask, and
// flags requests with a bad length or that fall outside the frame.
// ----------------------------------------------------------------------------
module fsp_front #(
  parameter int FRAME_BYTES = 8
) (
  input  fsp_pkg::req_t req,
  output fsp_pkg::cmd_t cmd
);

  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int FRAME_WORDS = FRAME_BYTES / 4;
  localparam int PW          = $clog2(FRAME_BITS + 128) + 2;

  localparam logic signed [PW-1:0] FB_C  = PW'(FRAME_BITS);
  localparam logic signed [PW-1:0] FBM_C = PW'(FRAME_BITS - 1);

  logic signed [PW-1:0] s_ext;
  logic signed [PW-1:0] n_ext;
  logic signed [PW-1:0] pos;
  logic signed [PW-1:0] pos_end;
  logic                 bad_len;
  logic                 out_frame;
  logic                 raw_op;
  logic [5:0]           shr;

  always_comb begin
    s_ext = $signed({{(PW-6){1'b0}}, req.start_bit});
    n_ext = $signed({{(PW-6){1'b0}}, req.length_bits});

    // linear bit position per numbering format
    case (req.format)
      fsp_pkg::FMT_INTEL_SEQ: pos = $signed({{(PW-6){1'b0}},
                                             req.start_bit ^ fsp_pkg::SEQ_FLIP});
      fsp_pkg::FMT_MOTO_LSB:  pos = $signed({{(PW-6){1'b0}},
                                             req.start_bit ^ fsp_pkg::LSB_FLIP});
      fsp_pkg::FMT_MOTO_MSB:  pos = ($signed({{(PW-6){1'b0}},
                                              req.start_bit ^ fsp_pkg::SEQ_FLIP})
                                     + n_ext - PW'(1)) ^ FBM_C;
      fsp_pkg::FMT_MOTO_SEQ:  pos = FB_C - n_ext - s_ext;
      default:                pos = s_ext;
    endcase

    pos_end   = pos + n_ext;
    bad_len   = (req.length_bits == 6'd0) || (req.length_bits > fsp_pkg::MAX_LEN);
    out_frame = pos[PW-1] || (pos_end > FB_C);
    raw_op    = (req.func == fsp_pkg::FUNC_LOAD) || (req.func == fsp_pkg::FUNC_READ);

    // mask of length_bits ones, all ones at full length
    shr = fsp_pkg::MAX_LEN - req.length_bits;

    cmd.func = req.func;
    cmd.moto = (req.format == fsp_pkg::FMT_MOTO_LSB) ||
               (req.format == fsp_pkg::FMT_MOTO_MSB) ||
               (req.format == fsp_pkg::FMT_MOTO_SEQ);
    cmd.mask = 32'hFFFF_FFFF >> shr[4:0];
    if (raw_op) begin
      cmd.reject  = (32'(req.word_index) >= 32'(FRAME_WORDS));
      cmd.word    = fsp_pkg::WORD_W'(req.word_index);
      cmd.bit_ofs = 5'd0;
      cmd.value   = req.write_value;
    end else begin
      cmd.reject  = bad_len || out_frame;
      cmd.word    = pos[5 +: fsp_pkg::WORD_W];
      cmd.bit_ofs = pos[4:0];
      cmd.value   = req.write_value & cmd.mask;
    end
  end

endmodule

FILE: hdl/fsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_queue - two-entry item queue
// Holds classified items between the front and back parts.
// ----------------------------------------------------------------------------
module fsp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fsp_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output fsp_pkg::head_t head,
  output logic           full
);

  fsp_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic [1:0]    count_next;

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !(pop && count != 2'd0)) begin
      count_next = count + 2'd1;
    end else if (!push && pop && count != 2'd0) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && count != 2'd0) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd   = entries[rd_ptr];
  assign full       = (count == 2'd2);

endmodule

FILE: hdl/fsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_back - frame buffer and executor
// Holds the frame words and runs one item per cycle: insert by read-modify-write
// of the two affected words, extract, raw load/read, and the result strobe.
// ----------------------------------------------------------------------------
module fsp_back #(
  parameter int FRAME_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  fsp_pkg::head_t head,
  output logic           pop,
  output logic           done,
  output fsp_pkg::rsp_t  rsp
);

  localparam int FRAME_WORDS = FRAME_BYTES / 4;
  localparam int IW          = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int XW          = fsp_pkg::WORD_W + 1;
  localparam logic [XW-1:0] FW_C = XW'(FRAME_WORDS);

  logic [31:0]   frame_words      [FRAME_WORDS];
  logic [31:0]   frame_words_next [FRAME_WORDS];
  fsp_pkg::cmd_t c;
  logic [XW-1:0] w_lo;
  logic [XW-1:0] w_hi;
  logic [XW-1:0] p_lo;
  logic [XW-1:0] p_hi;
  logic          ok_lo;
  logic          ok_hi;
  logic [31:0]   lo;
  logic [31:0]   hi;
  logic [63:0]   pair;
  logic [63:0]   m64;
  logic [63:0]   v64;
  logic [63:0]   pair_new;
  logic [63:0]   pair_shr;
  fsp_pkg::rsp_t rsp_next;

  assign c   = head.cmd;
  assign pop = head.valid;

  // linear word view and read-modify-write
  always_comb begin
    w_lo  = {1'b0, c.word};
    w_hi  = w_lo + XW'(1);
    ok_lo = (w_lo < FW_C);
    ok_hi = (w_hi < FW_C);
    p_lo  = c.moto ? (FW_C - XW'(1) - w_lo) : w_lo;
    p_hi  = c.moto ? (FW_C - XW'(1) - w_hi) : w_hi;

    lo = 32'd0;
    hi = 32'd0;
    if (ok_lo) begin
      lo = c.moto ? fsp_pkg::byte_rev(frame_words[p_lo[IW-1:0]])
                  : frame_words[p_lo[IW-1:0]];
    end
    if (ok_hi) begin
      hi = c.moto ? fsp_pkg::byte_rev(frame_words[p_hi[IW-1:0]])
                  : frame_words[p_hi[IW-1:0]];
    end

    pair     = {hi, lo};
    pair_shr = pair >> c.bit_ofs;
    m64      = {32'd0, c.mask} << c.bit_ofs;
    v64      = {32'd0, c.value} << c.bit_ofs;
    pair_new = (pair & ~m64) | v64;

    frame_words_next = frame_words;
    rsp_next.read_value = 32'd0;
    rsp_next.status     = c.reject;

    if (!c.reject) begin
      case (c.func)
        fsp_pkg::FUNC_INSERT: begin
          if (ok_lo) begin
            frame_words_next[p_lo[IW-1:0]] = c.moto ? fsp_pkg::byte_rev(pair_new[31:0])
                                                    : pair_new[31:0];
          end
          if (ok_hi) begin
            frame_words_next[p_hi[IW-1:0]] = c.moto ? fsp_pkg::byte_rev(pair_new[63:32])
                                                    : pair_new[63:32];
          end
        end
        fsp_pkg::FUNC_EXTRACT: begin
          rsp_next.read_value = pair_shr[31:0] & c.mask;
        end
        fsp_pkg::FUNC_LOAD: begin
          frame_words_next[w_lo[IW-1:0]] = c.value;
        end
        fsp_pkg::FUNC_READ: begin
          rsp_next.read_value = frame_words[w_lo[IW-1:0]];
        end
        default: begin
          rsp_next.read_value = 32'd0;
        end
      endcase
    end
  end

  // frame buffer, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_WORDS; i++) begin
        frame_words[i] <= 32'd0;
      end
    end else if (head.valid) begin
      frame_words <= frame_words_next;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head.valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: hdl/frame_signal_pack_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_signal_pack_unpack - signal insert/extract on a frame buffer
// Intel and Motorola bit numberings over a buffer of 32-bit frame words,
// plus raw word load and read.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload    direction
//  -------   ----------------   --------   ---------
//  request   start / busy       cmd        in
//  result    done (one cycle)   rsp        out
//
// one item per cycle sustained while busy is low; an accepted item is
// written into a queue entry, then executed, and the back part registers
// rsp and done; the back part pops and executes the queue head every
// cycle, so busy rises only when both queue entries are taken
// synchronous reset clears the queue, the strobe and the frame words
// results cannot be held off; done is high for exactly one cycle per item
// ----------------------------------------------------------------------------
module frame_signal_pack_unpack #(
  parameter int FRAME_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fsp_pkg::req_t cmd,
  output logic          done,
  output fsp_pkg::rsp_t rsp
);

  fsp_pkg::cmd_t  front_cmd;
  fsp_pkg::head_t head;
  logic           pop;
  logic           full;

  // classify incoming item
  fsp_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .req(cmd),
    .cmd(front_cmd)
  );

  // decoupling queue
  fsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (start && !busy),
    .push_cmd(front_cmd),
    .pop     (pop),
    .head    (head),
    .full    (full)
  );

  // execute against the frame buffer
  fsp_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk (clk),
    .rst (rst),
    .head(head),
    .pop (pop),
    .done(done),
    .rsp (rsp)
  );

  assign busy = full;

endmodule
